// ===== src/mlqs_pkg.sv =====
package mlqs_pkg;

  localparam int TIME_W   = 20;
  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int LEVEL_W  = 2;
  localparam int STATUS_W = 3;
  localparam int QUANT_W  = 8;

  localparam int MAX_JOBS_DEF = 64;

  localparam logic [QUANT_W-1:0] QUANTUM_ONE_RST = 8'd3;
  localparam logic [QUANT_W-1:0] QUANTUM_TWO_RST = 8'd5;
  localparam logic [TIME_W-1:0]  TIME_MAX        = 20'hFFFFF;

  // configuration register indexes
  localparam logic CFG_QUANTUM_ONE = 1'b0;
  localparam logic CFG_QUANTUM_TWO = 1'b1;

  // ready queue numbers (job level minus one)
  localparam logic [1:0] QUEUE_ONE   = 2'd0;
  localparam logic [1:0] QUEUE_TWO   = 2'd1;
  localparam logic [1:0] QUEUE_THREE = 2'd2;

  // job level that is dropped on admission
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ORDER    = 3'd2,
    ST_SLICE    = 3'd3,
    ST_ALL_DONE = 3'd4
  } status_t;

  localparam logic CMD_ARRIVE   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst_length;
    logic [TIME_W-1:0]  arrival_stamp;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic [LEVEL_W-1:0] level;
  } slot_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    ran_job_id;
    logic [LEVEL_W-1:0] ran_level;
    logic [TIME_W-1:0]  slice_start;
    logic [BURST_W-1:0] slice_length;
    logic               job_finished;
    logic [TIME_W-1:0]  completion_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  waiting_time;
    logic [TIME_W-1:0]  first_start_time;
  } res_t;

  // handoff from front queue to engine
  typedef struct packed {
    logic  avail;
    item_t item;
  } front_t;

endpackage

// ===== src/mlqs_front.sv =====
module mlqs_front
  import mlqs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  item_t  in_item,
  output front_t front,
  input  logic   take
);

  item_t      ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall    = (count == 2'd2);
  assign push        = in_valid && !in_stall;
  assign pop         = take && (count != 2'd0);
  assign front.avail = (count != 2'd0);
  assign front.item  = ent[rd_ptr];

  // command word storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/mlqs_engine.sv =====
module mlqs_engine
  import mlqs_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  front_t             front,
  output logic               take,
  input  logic [QUANT_W-1:0] quantum_one,
  input  logic [QUANT_W-1:0] quantum_two,
  output logic               out_valid,
  input  logic               out_stall,
  output res_t               out_res
);

  localparam int SW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] N_C    = CW'(MAX_JOBS);
  localparam logic [CW-1:0] LAST_C = CW'(MAX_JOBS - 1);
  localparam logic [CW:0]   N_W    = (CW + 1)'(MAX_JOBS);

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_SCAN, S_HEAD, S_SEL, S_RUN, S_FIN, S_CALC, S_EMIT
  } state_t;

  state_t              state;
  item_t               cur;
  res_t                res;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   last_arr;
  logic [MAX_JOBS-1:0] valid;
  logic [MAX_JOBS-1:0] admitted;
  logic [CW-1:0]       scan_i;
  logic                ev;
  logic [SW-1:0]       ev_idx;
  logic                best_v;
  logic [SW-1:0]       best_slot;
  logic [ID_W-1:0]     best_id;
  logic [LEVEL_W-1:0]  best_lvl;
  logic                min_v;
  logic [TIME_W-1:0]   min_arr;
  logic                post;
  logic [1:0]          q;
  logic [SW-1:0]       head [3];
  logic [CW-1:0]       cnt [3];
  logic [SW-1:0]       s;
  logic                fin;
  logic [TIME_W-1:0]   r_arr;
  logic [BURST_W-1:0]  r_burst;
  logic [TIME_W-1:0]   r_tat;

  // memories
  slot_t               slot_mem [MAX_JOBS];
  logic [BURST_W-1:0]  rem_mem [MAX_JOBS];
  logic [TIME_W:0]     fs_mem [MAX_JOBS];
  logic [SW-1:0]       fifo_mem [3][MAX_JOBS];
  slot_t               slot_q;
  logic [BURST_W-1:0]  rem_q;
  logic [TIME_W:0]     fs_q;
  logic [SW-1:0]       fifo_q;

  logic                slot_rd_en;
  logic [SW-1:0]       slot_rd_addr;
  logic                new_we;
  logic [SW-1:0]       new_addr;
  logic                run_we;
  logic                fifo_we;
  logic [1:0]          fifo_wl;
  logic [SW-1:0]       fifo_wa;
  logic [SW-1:0]       fifo_wd;

  logic [SW-1:0]       tail [3];
  logic [SW-1:0]       head_inc [3];
  logic                scan_more;
  logic                scan_end;
  logic                elig;
  logic                late_arr;
  logic [SW-1:0]       free_idx;
  logic                any_ready;
  logic [1:0]          pick_q;
  logic [1:0]          best_q;
  logic [BURST_W-1:0]  quantum;
  logic [BURST_W-1:0]  run;
  logic [TIME_W:0]     now_sum;
  logic [TIME_W-1:0]   now_sat;
  logic [TIME_W-1:0]   first;

  // queue tail and head wrap per level
  always_comb begin
    logic [CW:0] sum;
    for (int l = 0; l < 3; l++) begin
      sum = {{(CW + 1 - SW){1'b0}}, head[l]} + {1'b0, cnt[l]};
      if (sum >= N_W) sum = sum - N_W;
      tail[l]     = sum[SW-1:0];
      head_inc[l] = (head[l] == LAST_C[SW-1:0]) ? '0 : head[l] + 1'b1;
    end
  end

  assign scan_more = (scan_i < N_C);
  assign scan_end  = (scan_i == N_C) && !ev;
  assign elig      = ev && valid[ev_idx] && !admitted[ev_idx];
  assign late_arr  = (cur.arrival_stamp < last_arr);
  assign free_idx  = scan_i[SW-1:0];
  assign best_q    = best_lvl - 2'd1;

  assign any_ready = (cnt[0] != '0) || (cnt[1] != '0) || (cnt[2] != '0);
  assign pick_q    = (cnt[0] != '0) ? QUEUE_ONE :
                     (cnt[1] != '0) ? QUEUE_TWO : QUEUE_THREE;

  // slice arithmetic
  always_comb begin
    case (q)
      QUEUE_ONE: quantum = (quantum_one == '0) ? 16'd1 : {8'd0, quantum_one};
      QUEUE_TWO: quantum = (quantum_two == '0) ? 16'd1 : {8'd0, quantum_two};
      default:   quantum = rem_q;
    endcase
    run     = (quantum < rem_q) ? quantum : rem_q;
    now_sum = {1'b0, now} + {5'd0, run};
    now_sat = now_sum[TIME_W] ? TIME_MAX : now_sum[TIME_W-1:0];
    first   = fs_q[TIME_W] ? fs_q[TIME_W-1:0] : now;
  end

  // memory port control
  assign take         = (state == S_IDLE) && front.avail;
  assign slot_rd_en   = ((state == S_SCAN) && scan_more) || (state == S_SEL);
  assign slot_rd_addr = (state == S_SEL) ? fifo_q : scan_i[SW-1:0];
  assign new_we       = (state == S_FREE) && !late_arr && !valid[free_idx];
  assign new_addr     = free_idx;
  assign run_we       = (state == S_RUN);

  always_comb begin
    fifo_we = 1'b0;
    fifo_wl = best_q;
    fifo_wa = tail[best_q];
    fifo_wd = best_slot;
    if ((state == S_SCAN) && scan_end && best_v && (best_lvl != LEVEL_NONE)) begin
      fifo_we = 1'b1;
    end else if ((state == S_FIN) && !fin && (q != QUEUE_THREE)) begin
      fifo_we = 1'b1;
      fifo_wl = q;
      fifo_wa = tail[q];
      fifo_wd = s;
    end
  end

  // job record memory
  always_ff @(posedge clk) begin
    if (new_we) slot_mem[new_addr] <= slot_t'{cur.job_id, cur.burst_length,
                                              cur.arrival_stamp, cur.level};
    if (slot_rd_en) slot_q <= slot_mem[slot_rd_addr];
  end

  // remaining time memory
  always_ff @(posedge clk) begin
    if (new_we) rem_mem[new_addr] <= cur.burst_length;
    else if (run_we) rem_mem[s] <= rem_q - run;
    if (state == S_SEL) rem_q <= rem_mem[fifo_q];
  end

  // first start memory, top bit marks a recorded start
  always_ff @(posedge clk) begin
    if (new_we) fs_mem[new_addr] <= '0;
    else if (run_we && !fs_q[TIME_W]) fs_mem[s] <= {1'b1, now};
    if (state == S_SEL) fs_q <= fs_mem[fifo_q];
  end

  // ready queue memory
  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_wl][fifo_wa] <= fifo_wd;
    if (state == S_HEAD) fifo_q <= fifo_mem[q][head[q]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now       <= '0;
      last_arr  <= '0;
      valid     <= '0;
      admitted  <= '0;
      out_valid <= 1'b0;
      scan_i    <= '0;
      ev        <= 1'b0;
      best_v    <= 1'b0;
      min_v     <= 1'b0;
      post      <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        head[l] <= '0;
        cnt[l]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (front.avail) begin
            cur    <= front.item;
            res    <= '0;
            scan_i <= '0;
            ev     <= 1'b0;
            best_v <= 1'b0;
            min_v  <= 1'b0;
            post   <= 1'b0;
            if (front.item.cmd == CMD_DISPATCH) begin
              state <= S_SCAN;
            end else begin
              state <= S_FREE;
            end
          end
        end
        // order check, then lowest free slot, one per cycle
        S_FREE: begin
          if (late_arr) begin
            res.status <= ST_ORDER;
            state      <= S_EMIT;
          end else if (!valid[free_idx]) begin
            valid[free_idx]    <= 1'b1;
            admitted[free_idx] <= 1'b0;
            last_arr           <= cur.arrival_stamp;
            res.status         <= ST_ACCEPTED;
            state              <= S_EMIT;
          end else if (scan_i == LAST_C) begin
            res.status <= ST_FULL;
            state      <= S_EMIT;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        // table pass: smallest due id, and earliest pending arrival
        S_SCAN: begin
          if (scan_more) begin
            scan_i <= scan_i + 1'b1;
            ev     <= 1'b1;
            ev_idx <= scan_i[SW-1:0];
          end else begin
            ev <= 1'b0;
          end
          if (elig) begin
            if (slot_q.arrival <= now && (!best_v || slot_q.id < best_id)) begin
              best_v    <= 1'b1;
              best_slot <= ev_idx;
              best_id   <= slot_q.id;
              best_lvl  <= slot_q.level;
            end
            if (!min_v || slot_q.arrival < min_arr) begin
              min_v   <= 1'b1;
              min_arr <= slot_q.arrival;
            end
          end
          if (scan_end) begin
            scan_i <= '0;
            best_v <= 1'b0;
            min_v  <= 1'b0;
            if (best_v) begin
              if (best_lvl == LEVEL_NONE) begin
                valid[best_slot] <= 1'b0;
              end else begin
                admitted[best_slot] <= 1'b1;
                cnt[best_q]         <= cnt[best_q] + 1'b1;
              end
            end else if (post) begin
              state <= S_FIN;
            end else if (any_ready) begin
              q     <= pick_q;
              state <= S_HEAD;
            end else if (min_v) begin
              now <= min_arr;
            end else begin
              res.status <= ST_ALL_DONE;
              state      <= S_EMIT;
            end
          end
        end
        S_HEAD: state <= S_SEL;
        S_SEL: begin
          s     <= fifo_q;
          state <= S_RUN;
        end
        // one slice
        S_RUN: begin
          res.status           <= ST_SLICE;
          res.ran_job_id       <= slot_q.id;
          res.ran_level        <= slot_q.level;
          res.slice_start      <= now;
          res.slice_length     <= run;
          res.first_start_time <= first;
          r_arr                <= slot_q.arrival;
          r_burst              <= slot_q.burst;
          fin                  <= (rem_q == run);
          now                  <= now_sat;
          post                 <= 1'b1;
          scan_i               <= '0;
          ev                   <= 1'b0;
          best_v               <= 1'b0;
          min_v                <= 1'b0;
          state                <= S_SCAN;
        end
        // retire or requeue
        S_FIN: begin
          if (fin) begin
            head[q]             <= head_inc[q];
            cnt[q]              <= cnt[q] - 1'b1;
            valid[s]            <= 1'b0;
            admitted[s]         <= 1'b0;
            res.job_finished    <= 1'b1;
            res.completion_time <= now;
            r_tat               <= (now >= r_arr) ? now - r_arr : '0;
            state               <= S_CALC;
          end else begin
            if (q != QUEUE_THREE) head[q] <= head_inc[q];
            state <= S_EMIT;
          end
        end
        S_CALC: begin
          res.turnaround_time <= r_tat;
          res.waiting_time    <= (r_tat >= {4'd0, r_burst}) ? r_tat - {4'd0, r_burst} : '0;
          state               <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/multilevel_queue_scheduler_top.sv =====
// Three-level job scheduler: levels one and two are round robin with
// programmable quanta, level three runs jobs to completion in arrival order.
// Each input word gives exactly one result word. An arrive word runs the order
// check, then the one-slot-per-cycle search for the lowest free table slot.
// A dispatch word walks the job table in passes: one pass per job admitted or
// dropped, one closing pass before the slice, one more per time jump, and one
// closing pass after the slice, one at a time through the single read port of
// the job table; a dispatch with no job stored makes a single pass. A two-word
// input queue and an output register let either side stall without holding up
// the other.
module multilevel_queue_scheduler_top
  import mlqs_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [ID_W-1:0]     job_id,
  input  logic [BURST_W-1:0]  burst_length,
  input  logic [TIME_W-1:0]   arrival_stamp,
  input  logic [LEVEL_W-1:0]  level,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     ran_job_id,
  output logic [LEVEL_W-1:0]  ran_level,
  output logic [TIME_W-1:0]   slice_start,
  output logic [BURST_W-1:0]  slice_length,
  output logic                job_finished,
  output logic [TIME_W-1:0]   completion_time,
  output logic [TIME_W-1:0]   turnaround_time,
  output logic [TIME_W-1:0]   waiting_time,
  output logic [TIME_W-1:0]   first_start_time,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [QUANT_W-1:0]  cfg_data
);

  logic [QUANT_W-1:0] quantum_one;
  logic [QUANT_W-1:0] quantum_two;
  front_t             front;
  logic               take;
  res_t               res;

  assign cfg_ready = 1'b1;

  // quantum registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_one <= QUANTUM_ONE_RST;
      quantum_two <= QUANTUM_TWO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUANTUM_ONE: quantum_one <= cfg_data;
        CFG_QUANTUM_TWO: quantum_two <= cfg_data;
        default:         quantum_one <= quantum_one;
      endcase
    end
  end

  mlqs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (item_t'{cmd, job_id, burst_length, arrival_stamp, level}),
    .front    (front),
    .take     (take)
  );

  mlqs_engine #(
    .MAX_JOBS (MAX_JOBS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .front       (front),
    .take        (take),
    .quantum_one (quantum_one),
    .quantum_two (quantum_two),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  // result word fields
  assign status           = res.status;
  assign ran_job_id       = res.ran_job_id;
  assign ran_level        = res.ran_level;
  assign slice_start      = res.slice_start;
  assign slice_length     = res.slice_length;
  assign job_finished     = res.job_finished;
  assign completion_time  = res.completion_time;
  assign turnaround_time  = res.turnaround_time;
  assign waiting_time     = res.waiting_time;
  assign first_start_time = res.first_start_time;

`ifndef NO_ASSERTIONS
  // only a slice word carries a job
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_SLICE) |-> (ran_job_id == '0) && (slice_length == '0))
    else $error("non-slice word carries slice fields");

  // finishing figures only with a finished job
  a_fin_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !job_finished |-> (completion_time == '0) && (waiting_time == '0))
    else $error("completion figures without finish");

  // a finished job completes at slice end
  a_fin_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && job_finished |-> (status == ST_SLICE) &&
      (completion_time >= slice_start) && (turnaround_time >= waiting_time))
    else $error("inconsistent completion figures");
`endif

endmodule

// ===== dv/multilevel_queue_scheduler_top_test.sv =====
module multilevel_queue_scheduler_top_test;
  import mlqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = MAX_JOBS_DEF;
  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;

  // scheduler predictor and expected word store
  class sched_scoreboard;
    bit s_valid[NSLOTS];
    bit s_adm[NSLOTS];
    bit [ID_W-1:0] s_id[NSLOTS];
    bit [BURST_W-1:0] s_burst[NSLOTS];
    bit [TIME_W-1:0] s_arr[NSLOTS];
    bit [LEVEL_W-1:0] s_lvl[NSLOTS];
    int unsigned remaining[NSLOTS];
    int unsigned first_start[NSLOTS];
    bit fs_ok[NSLOTS];
    int ready_q[3][$];
    int unsigned now;
    int unsigned last_arr;
    bit [QUANT_W-1:0] quantum_one;
    bit [QUANT_W-1:0] quantum_two;
    res_t expected_results[$];
    int errors;

    function new();
      now = 0;
      last_arr = 0;
      quantum_one = QUANTUM_ONE_RST;
      quantum_two = QUANTUM_TWO_RST;
      errors = 0;
      foreach (s_valid[i]) begin
        s_valid[i] = 0;
        s_adm[i] = 0;
        fs_ok[i] = 0;
      end
    endfunction

    function void set_quantum(logic idx, bit [QUANT_W-1:0] d);
      if (idx == CFG_QUANTUM_ONE) quantum_one = d;
      else quantum_two = d;
    endfunction

    function void add_expected(res_t r);
      expected_results.insert(expected_results.size(), r);
    endfunction

    // move arrived jobs into their ready queues, smallest id first
    function void admit_jobs(int unsigned t);
      int best;
      int lq;
      forever begin
        best = -1;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!s_valid[i] || s_adm[i] || s_arr[i] > t) continue;
          if (best < 0 || s_id[i] < s_id[best]) best = i;
        end
        if (best < 0) return;
        if (s_lvl[best] == LEVEL_NONE) s_valid[best] = 0;
        else begin
          s_adm[best] = 1;
          lq = int'(s_lvl[best]) - 1;
          ready_q[lq].insert(ready_q[lq].size(), best);
        end
      end
    endfunction

    function void note_word(item_t w);
      res_t r;
      int q, s, free_slot;
      bit any;
      int unsigned mn, quant, run, start, ct, tat, wt;
      r = '0;
      if (w.cmd == CMD_ARRIVE) begin
        free_slot = -1;
        for (int i = 0; i < NSLOTS; i++)
          if (!s_valid[i] && free_slot < 0) free_slot = i;
        if (w.arrival_stamp < last_arr) r.status = ST_ORDER;
        else if (free_slot < 0) r.status = ST_FULL;
        else begin
          s_valid[free_slot] = 1;
          s_adm[free_slot] = 0;
          s_id[free_slot] = w.job_id;
          s_burst[free_slot] = w.burst_length;
          s_arr[free_slot] = w.arrival_stamp;
          s_lvl[free_slot] = w.level;
          remaining[free_slot] = w.burst_length;
          first_start[free_slot] = 0;
          fs_ok[free_slot] = 0;
          last_arr = w.arrival_stamp;
          r.status = ST_ACCEPTED;
        end
        add_expected(r);
        return;
      end
      // find work, jumping time forward when nothing is ready
      q = -1;
      for (int iter = 0; iter < NSLOTS + 2 && q < 0; iter++) begin
        admit_jobs(now);
        for (int l = 2; l >= 0; l--)
          if (ready_q[l].size() > 0) q = l;
        if (q >= 0) break;
        any = 0;
        mn = 0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!s_valid[i] || s_adm[i]) continue;
          if (!any || s_arr[i] < mn) begin
            mn = s_arr[i];
            any = 1;
          end
        end
        if (!any) break;
        now = mn;
      end
      if (q < 0) begin
        r.status = ST_ALL_DONE;
        add_expected(r);
        return;
      end
      s = ready_q[q][0];
      if (!fs_ok[s]) begin
        fs_ok[s] = 1;
        first_start[s] = now;
      end
      if (q == QUEUE_ONE) quant = (quantum_one != 0) ? quantum_one : 1;
      else if (q == QUEUE_TWO) quant = (quantum_two != 0) ? quantum_two : 1;
      else quant = remaining[s];
      run = (quant < remaining[s]) ? quant : remaining[s];
      start = now;
      remaining[s] -= run;
      now += run;
      if (now > TIME_MAX) now = TIME_MAX;
      admit_jobs(now);
      r.status = ST_SLICE;
      r.ran_job_id = s_id[s];
      r.ran_level = s_lvl[s];
      r.slice_start = TIME_W'(start);
      r.slice_length = BURST_W'(run);
      r.first_start_time = TIME_W'(first_start[s]);
      if (remaining[s] == 0) begin
        ct = now;
        tat = (ct >= s_arr[s]) ? ct - s_arr[s] : 0;
        wt = (tat >= s_burst[s]) ? tat - s_burst[s] : 0;
        ready_q[q].delete(0);
        s_valid[s] = 0;
        s_adm[s] = 0;
        r.job_finished = 1;
        r.completion_time = TIME_W'(ct);
        r.turnaround_time = TIME_W'(tat);
        r.waiting_time = TIME_W'(wt);
      end else if (q < QUEUE_THREE) begin
        ready_q[q].delete(0);
        ready_q[q].insert(ready_q[q].size(), s);
      end
      add_expected(r);
    endfunction

    function void check_word(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = expected_results[0];
      expected_results.delete(0);
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic cmd = 0;
  logic [ID_W-1:0] job_id = '0;
  logic [BURST_W-1:0] burst_length = '0;
  logic [TIME_W-1:0] arrival_stamp = '0;
  logic [LEVEL_W-1:0] level = '0;
  logic out_valid;
  logic out_stall = 1;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0] ran_job_id;
  logic [LEVEL_W-1:0] ran_level;
  logic [TIME_W-1:0] slice_start;
  logic [BURST_W-1:0] slice_length;
  logic job_finished;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic [TIME_W-1:0] first_start_time;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = CFG_QUANTUM_ONE;
  logic [QUANT_W-1:0] cfg_data = '0;

  sched_scoreboard sb;
  bit calm = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int unsigned gen_last = 0;
  int idle_cycles = 0;

  multilevel_queue_scheduler_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watch both channels and score words
  always @(posedge clk) begin
    res_t got;
    bit moved;
    moved = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_word({cmd, job_id, burst_length, arrival_stamp, level});
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        got.status = status_t'(status);
        got.ran_job_id = ran_job_id;
        got.ran_level = ran_level;
        got.slice_start = slice_start;
        got.slice_length = slice_length;
        got.job_finished = job_finished;
        got.completion_time = completion_time;
        got.turnaround_time = turnaround_time;
        got.waiting_time = waiting_time;
        got.first_start_time = first_start_time;
        sb.check_word(got);
        moved = 1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall <= 1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_done <= 1;
      out_stall <= 0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  task automatic send_word(logic c, logic [ID_W-1:0] id, logic [BURST_W-1:0] b,
                           logic [TIME_W-1:0] a, logic [LEVEL_W-1:0] l);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    job_id <= id;
    burst_length <= b;
    arrival_stamp <= a;
    level <= l;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_quanta(logic [QUANT_W-1:0] q1, logic [QUANT_W-1:0] q2);
    cfg_valid <= 1;
    cfg_index <= CFG_QUANTUM_ONE;
    cfg_data <= q1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_quantum(CFG_QUANTUM_ONE, q1);
    cfg_index <= CFG_QUANTUM_TWO;
    cfg_data <= q2;
    do @(posedge clk); while (!cfg_ready);
    sb.set_quantum(CFG_QUANTUM_TWO, q2);
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // well-formed arrivals and dispatches with some out-of-order noise
  task automatic run_random(int n, int arrive_pct);
    int r;
    int unsigned delta;
    logic [BURST_W-1:0] b;
    logic [LEVEL_W-1:0] l;
    logic [ID_W-1:0] id;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      id = ($urandom_range(99) < 20) ? ID_W'($urandom_range(0, 3))
                                      : ID_W'($urandom_range(0, 255));
      if (r < arrive_pct) begin
        delta = ($urandom_range(99) < 2) ? $urandom_range(0, 30000) : $urandom_range(0, 25);
        if (gen_last + delta <= 1000000) gen_last += delta;
        l = ($urandom_range(99) < 3) ? LEVEL_NONE : LEVEL_W'($urandom_range(1, 3));
        if (l == 2'd3 && $urandom_range(99) < 8) b = BURST_W'($urandom_range(0, 65535));
        else b = BURST_W'($urandom_range(0, 12));
        send_word(CMD_ARRIVE, id, b, TIME_W'(gen_last), l);
      end else if (r < arrive_pct + 5 && gen_last > 0) begin
        send_word(CMD_ARRIVE, id, BURST_W'($urandom),
                  TIME_W'($urandom_range(0, gen_last - 1)), LEVEL_W'($urandom));
      end else begin
        send_word(CMD_DISPATCH, id, BURST_W'($urandom), TIME_W'($urandom),
                  LEVEL_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero burst, equal ids, level zero, out of order, extremes
    write_quanta(QUANTUM_ONE_RST, QUANTUM_TWO_RST);
    send_word(CMD_DISPATCH, 8'd0, 16'd0, 20'd0, 2'd0);
    send_word(CMD_ARRIVE, 8'd5, 16'd4, 20'd0, 2'd1);
    send_word(CMD_ARRIVE, 8'd2, 16'd0, 20'd0, 2'd2);
    send_word(CMD_ARRIVE, 8'd2, 16'd7, 20'd0, 2'd3);
    send_word(CMD_ARRIVE, 8'd255, 16'd65535, 20'd3, 2'd3);
    send_word(CMD_ARRIVE, 8'd0, 16'd9, 20'd3, LEVEL_NONE);
    send_word(CMD_ARRIVE, 8'd9, 16'd1, 20'd1, 2'd1);
    send_word(CMD_ARRIVE, 8'd7, 16'd3, 20'd40, 2'd2);
    repeat (9) send_word(CMD_DISPATCH, 8'hFF, 16'hFFFF, 20'hFFFFF, 2'd3);
    gen_last = 40;
    run_random(240, 50);
    wait_drained();

    // no idling on either side
    write_quanta(8'd0, 8'd255);
    calm = 1;
    run_random(250, 50);
    wait_drained();
    calm = 0;

    // fill the table while the receiver holds off
    write_quanta(8'd255, 8'd1);
    hold_req <= 1;
    run_random(250, 85);
    run_random(60, 5);
    wait_drained();

    write_quanta(8'd1, 8'd0);
    run_random(300, 45);
    wait_drained();

    write_quanta(QUANT_W'($urandom_range(1, 255)), QUANT_W'($urandom_range(1, 255)));
    run_random(220, 50);
    wait_drained();

    // time saturation near the top of the range
    write_quanta(8'd2, 8'd7);
    send_word(CMD_ARRIVE, 8'd17, 16'd65535, 20'd1048570, 2'd3);
    send_word(CMD_ARRIVE, 8'd18, 16'd65535, 20'hFFFFF, 2'd3);
    send_word(CMD_ARRIVE, 8'd19, 16'd5, 20'hFFFFF, 2'd1);
    send_word(CMD_ARRIVE, 8'd20, 16'd1, 20'd0, 2'd2);
    repeat (8) send_word(CMD_DISPATCH, 8'd0, 16'd0, 20'd0, 2'd0);
    wait_drained();
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.expected_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== multilevel_queue_scheduler_top.f =====
src/mlqs_pkg.sv
src/mlqs_front.sv
src/mlqs_engine.sv
src/multilevel_queue_scheduler_top.sv
dv/multilevel_queue_scheduler_top_test.sv
